FILE: rtl/stack_allocator_lazy_free_assert.svh
// Assertion macros used by the allocator core.
`ifndef STACK_ALLOCATOR_LAZY_FREE_ASSERT_SVH
`define STACK_ALLOCATOR_LAZY_FREE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SAL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, checked outside reset.
`define SAL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

FILE: rtl/sal_pkg.sv
`timescale 1ns / 1ps
package sal_pkg;

  localparam int REQ_W     = 14;
  localparam int ADDR_W    = 12;
  localparam int STAT_W    = 3;
  localparam int USED_W    = 13;
  localparam int SIZE_W    = 13;
  localparam int MARK_W    = 2;
  localparam int HDR_WORDS = 2;
  localparam int ROUND_ADD = 3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [MARK_W-1:0] MARK_NONE   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED   = 2'd1;
  localparam logic [MARK_W-1:0] MARK_UNUSED = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_SPACE  = 3'd1,
    STAT_ZERO_SIZE = 3'd2,
    STAT_FREED     = 3'd3,
    STAT_BAD_PTR   = 3'd4
  } status_e;

  typedef struct packed {
    logic              opcode;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [USED_W-1:0] words_in_use;
    status_e           status;
    logic [ADDR_W-1:0] granted_address;
  } res_t;

endpackage

FILE: rtl/sal_ram.sv
`timescale 1ns / 1ps
module sal_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/sal_core.sv
`timescale 1ns / 1ps
`include "stack_allocator_lazy_free_assert.svh"
module sal_core
  import sal_pkg::*;
#(
  parameter int CAPACITY_WORDS = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int AW = $clog2(CAPACITY_WORDS);
  localparam int TW = $clog2(CAPACITY_WORDS + 1);
  localparam int CW = ((TW > SIZE_W) ? TW : SIZE_W) + 1;
  localparam int RW = MARK_W + SIZE_W;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY_WORDS);
  localparam logic [CW-1:0] HDR_C  = CW'(HDR_WORDS);
  localparam logic [AW-1:0] LAST_C = AW'(CAPACITY_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FREE_CHK,
    S_POP_RD,
    S_POP_CHK,
    S_RESP
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [TW-1:0]     top_q, top_d;
  logic              zero_q, zero_d;
  logic              inrng_q, inrng_d;
  logic [SIZE_W-1:0] words_q, words_d;
  logic [CW-1:0]     addr_q, addr_d;
  logic [ADDR_W-1:0] gr_q, gr_d;
  status_e           st_q, st_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [RW-1:0]     ram_wdata, ram_rdata;
  logic [MARK_W-1:0] rd_mark;
  logic [SIZE_W-1:0] rd_size;

  logic [REQ_W:0]    bytes_rnd;
  logic [CW-1:0]     top_ext, words_ext, need, slot, pop_p, pop_nxt, free_nxt, req_addr;

  assign rd_mark = ram_rdata[RW-1:SIZE_W];
  assign rd_size = ram_rdata[SIZE_W-1:0];

  assign bytes_rnd = {1'b0, req_i.request_bytes} + (REQ_W+1)'(ROUND_ADD);
  assign req_addr  = CW'(req_i.block_address);
  assign top_ext   = CW'(top_q);
  assign words_ext = CW'(words_q);
  assign need      = words_ext + HDR_C;
  assign slot      = top_ext - words_ext;
  assign pop_p     = top_ext + HDR_C;
  assign pop_nxt   = pop_p + CW'(rd_size);
  assign free_nxt  = addr_q + CW'(rd_size);

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o.granted_address = gr_q;
  assign res_o.status          = st_q;
  assign res_o.words_in_use    = USED_W'(CAP_C - top_ext);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    top_d     = top_q;
    zero_d    = zero_q;
    inrng_d   = inrng_q;
    words_d   = words_q;
    addr_d    = addr_q;
    gr_d      = gr_q;
    st_d      = st_q;
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = {MARK_NONE, {SIZE_W{1'b0}}};
    ram_re    = 1'b0;
    ram_raddr = req_addr[AW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == LAST_C) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          zero_d  = (req_i.request_bytes == '0);
          words_d = bytes_rnd[REQ_W:2];
          addr_d  = req_addr;
          inrng_d = (req_addr < CAP_C);
          gr_d    = '0;
          st_d    = STAT_OK;
          if (req_i.opcode == OP_ALLOC) begin
            state_d = S_ALLOC;
          end else begin
            ram_re  = (req_addr < CAP_C);
            state_d = S_FREE_CHK;
          end
        end
      end
      S_ALLOC: begin
        state_d = S_RESP;
        if (zero_q) begin
          st_d = STAT_ZERO_SIZE;
        end else if (top_ext < need) begin
          st_d = STAT_NO_SPACE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = slot[AW-1:0];
          ram_wdata = {MARK_USED, words_q};
          top_d     = TW'(slot - HDR_C);
          gr_d      = slot[ADDR_W-1:0];
        end
      end
      S_FREE_CHK: begin
        state_d = S_RESP;
        if (!inrng_q) begin
          st_d = STAT_BAD_PTR;
        end else if (rd_mark == MARK_UNUSED) begin
          st_d = STAT_FREED;
        end else if (rd_mark != MARK_USED) begin
          st_d = STAT_BAD_PTR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = addr_q[AW-1:0];
          ram_wdata = {MARK_UNUSED, rd_size};
          // The freed block is on top: pop it with the size just read.
          if (pop_p == addr_q) begin
            top_d   = (free_nxt > CAP_C) ? TW'(CAP_C) : TW'(free_nxt);
            state_d = S_POP_RD;
          end
        end
      end
      S_POP_RD: begin
        if (pop_p < CAP_C) begin
          ram_re    = 1'b1;
          ram_raddr = pop_p[AW-1:0];
          state_d   = S_POP_CHK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_POP_CHK: begin
        if (rd_mark == MARK_UNUSED) begin
          top_d   = (pop_nxt > CAP_C) ? TW'(CAP_C) : TW'(pop_nxt);
          state_d = S_POP_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      top_q   <= TW'(CAPACITY_WORDS);
      zero_q  <= 1'b0;
      inrng_q <= 1'b0;
      words_q <= '0;
      addr_q  <= '0;
      gr_q    <= '0;
      st_q    <= STAT_OK;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      top_q   <= top_d;
      zero_q  <= zero_d;
      inrng_q <= inrng_d;
      words_q <= words_d;
      addr_q  <= addr_d;
      gr_q    <= gr_d;
      st_q    <= st_d;
    end
  end

  sal_ram #(
    .WIDTH(RW),
    .DEPTH(CAPACITY_WORDS)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  `SAL_ASSERT_IMP(a_top_in_store, clk_i, rst_ni, 1'b1, top_ext <= CAP_C)
  `SAL_ASSERT_IMP(a_clear_writes_none, clk_i, rst_ni, state_q == S_CLEAR,
                  ram_we && ram_wdata[RW-1:SIZE_W] == MARK_NONE)
  `SAL_ASSERT_IMP(a_pop_no_write, clk_i, rst_ni,
                  state_q == S_POP_CHK || state_q == S_POP_RD, !ram_we)
  `SAL_ASSERT_NXT(a_resp_to_idle, clk_i, rst_ni, state_q == S_RESP && res_ready_i,
                  state_q == S_IDLE)

endmodule

FILE: rtl/sal_out_reg.sv
`timescale 1ns / 1ps
module sal_out_reg
  import sal_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  output logic res_ready_o,
  input  res_t res_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  logic vld_q, vld_d;
  logic load;
  res_t data_q;

  // The holding register takes a new result when it is empty or when the old one leaves.
  assign res_ready_o = !vld_q || out_ready_i;
  assign load        = res_valid_i && res_ready_o;
  assign out_valid_o = vld_q;
  assign out_o       = data_q;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

endmodule

FILE: rtl/stack_allocator_lazy_free.sv
// An allocate checks the space and writes the header, then responds; a free reads the header,
// then checks it and writes it back, then responds. No new item is taken before the response
// is accepted. A free of the top block also pops it and reads the next header unless the store
// is empty, popping each further unused block in the cascade until it meets a used one.
// After reset the header marks are cleared, one entry a cycle, during which no item is
// accepted; the top of the stack resets to an empty store.
`timescale 1ns / 1ps
module stack_allocator_lazy_free
  import sal_pkg::*;
#(
  parameter int CAPACITY_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // request_bytes[13:0], block_address[25:14], zero above
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // granted_address[11:0], status[14:12],
                                     // words_in_use[27:15], zero above
);

  req_t req;
  res_t core_res, out_res;
  logic res_valid, res_ready;

  assign req.opcode        = s_axis_tuser;
  assign req.request_bytes = s_axis_tdata[REQ_W-1:0];
  assign req.block_address = s_axis_tdata[REQ_W+ADDR_W-1:REQ_W];

  sal_core #(
    .CAPACITY_WORDS(CAPACITY_WORDS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (core_res)
  );

  sal_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_ready_o(res_ready),
    .res_i      (core_res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (out_res)
  );

  assign m_axis_tdata = {4'b0000, out_res.words_in_use, out_res.status,
                         out_res.granted_address};

endmodule
